// ===== rtl/core/lcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the line centroid steering unit.
// ----------------------------------------------------------------------------
package lcs_pkg;

   // default row length limit, sets the column counter width
   localparam int MAX_WIDTH_DEF = 1024;

   // fixed field widths
   localparam int CH_W    = 8;
   localparam int BASE_W  = 8;
   localparam int GAIN_W  = 16;
   localparam int IMG_W   = 11;
   localparam int SPEED_W = 16;
   localparam int CNT_W   = 11;               // white pixel count
   localparam int SUM_W   = 19;               // white column sum
   localparam int DIFF_W  = SUM_W + 1;        // signed centroid offset
   localparam int GP_W    = BASE_W + GAIN_W;  // base * gain
   localparam int K_W     = GP_W + DIFF_W;    // base * gain * |offset|
   localparam int FRAC_W  = 8;                // 8.8 fixed point
   localparam int STEP_W  = $clog2(SUM_W + 1);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SPEED      = 3'd0,
      CSR_STEER_GAIN      = 3'd1,
      CSR_WHITE_THRESHOLD = 3'd2,
      CSR_BLACK_THRESHOLD = 3'd3,
      CSR_IMAGE_WIDTH     = 3'd4
   } csr_index_type;

   // reset values of the registers
   localparam logic [BASE_W-1:0] BASE_SPEED_RST      = 8'd20;
   localparam logic [GAIN_W-1:0] STEER_GAIN_RST      = 16'd3277;
   localparam logic [CH_W-1:0]   WHITE_THRESHOLD_RST = 8'd250;
   localparam logic [CH_W-1:0]   BLACK_THRESHOLD_RST = 8'd20;
   localparam logic [IMG_W-1:0]  IMAGE_WIDTH_RST     = 11'd150;

   // spin speed is base * 512 / 3
   localparam logic [CNT_W-1:0] SPIN_DIVISOR = 11'd3;
   localparam int               SPIN_SHIFT   = 9;

   // saturation limits
   localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

   // row queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ACT_FORWARD = 3'd0,
      ACT_LEFT    = 3'd1,
      ACT_RIGHT   = 3'd2,
      ACT_SPIN    = 3'd3,
      ACT_FINISH  = 3'd4
   } steer_action_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            last_in_row;
   } req_item_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed;
      logic [SPEED_W-1:0] right_speed;
      steer_action_type   steer_action;
      logic               finish_line;
   } rsp_item_type;

   typedef struct packed {
      logic [BASE_W-1:0] base_speed;
      logic [GAIN_W-1:0] steer_gain;
      logic [CH_W-1:0]   white_threshold;
      logic [CH_W-1:0]   black_threshold;
      logic [IMG_W-1:0]  image_width;
   } cfg_type;

   // summary of one finished row, front to back
   typedef struct packed {
      logic             black;
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
   } row_sum_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/lcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_front
// Pixel classifier: accumulates white columns and the finish mark of a row
// and pushes a row summary into the queue on the last pixel.
// ----------------------------------------------------------------------------
module lcs_front import lcs_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_item_type     req_data,
   input  queue_status_type qstat,
   output logic             push,
   output row_sum_type      push_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             black_ff, black_in;
   logic             halted_ff, halted_in;

   logic             accept;
   logic             is_white, is_black;
   logic [SUM_W:0]   sum_add;
   logic [CNT_W-1:0] count_upd;
   logic [SUM_W-1:0] sum_upd;
   logic             black_upd;

   // a full queue holds off new items
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   // pixel classification
   assign is_white = (req_data.red   > cfg.white_threshold) &&
                     (req_data.green > cfg.white_threshold) &&
                     (req_data.blue  > cfg.white_threshold);
   assign is_black = (req_data.red   < cfg.black_threshold) &&
                     (req_data.green < cfg.black_threshold) &&
                     (req_data.blue  < cfg.black_threshold);

   // saturating accumulation
   assign sum_add = {1'b0, sum_ff} + (SUM_W+1)'(col_ff);

   always_comb begin
      sum_upd   = sum_ff;
      count_upd = count_ff;
      black_upd = black_ff;
      if (!black_ff) begin
         if (is_white) begin
            sum_upd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            if (count_ff != COUNT_MAX) begin
               count_upd = count_ff + 1'b1;
            end
         end
         if (is_black) begin
            black_upd = 1'b1;
         end
      end
   end

   // row bookkeeping and summary push
   always_comb begin
      col_in    = col_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      black_in  = black_ff;
      halted_in = halted_ff;
      push      = 1'b0;
      if (accept && !halted_ff) begin
         if (req_data.last_in_row) begin
            push      = 1'b1;
            col_in    = '0;
            count_in  = '0;
            sum_in    = '0;
            black_in  = 1'b0;
            halted_in = black_upd;
         end else begin
            count_in = count_upd;
            sum_in   = sum_upd;
            black_in = black_upd;
            if (!black_ff && col_ff != COL_LAST) begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   assign push_data.black = black_upd;
   assign push_data.count = count_upd;
   assign push_data.sum   = sum_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         black_ff  <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         black_ff  <= black_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ===== rtl/core/lcs_row_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_row_queue
// Short queue of row summaries between the front and the back.
// ----------------------------------------------------------------------------
module lcs_row_queue import lcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  row_sum_type      push_data,
   input  logic             pop,
   output row_sum_type      pop_data,
   output queue_status_type qstat
);

   row_sum_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QPTR_W:0]    fill_ff, fill_in;

   assign qstat.full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qstat.empty = (fill_ff == '0);
   assign pop_data    = entry_ff[rptr_ff];

   // pointer and fill update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_back
// Row-end engine: serial centroid divide, proportional gain multiply and
// wheel speed result register.
// ----------------------------------------------------------------------------
module lcs_back import lcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type qstat,
   output logic             pop,
   input  row_sum_type      pop_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_data
);

   typedef enum logic [4:0] {
      BK_IDLE = 5'b00001,
      BK_DIV  = 5'b00010,
      BK_DIFF = 5'b00100,
      BK_MUL  = 5'b01000,
      BK_DONE = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic                  finish_ff, spin_ff;
   logic                  pos_ff, neg_ff;
   logic [SUM_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      div_ff;
   logic [GP_W-1:0]       gp_ff;
   logic [DIFF_W-1:0]     mag_ff;
   logic [K_W-1:0]        k_ff;
   rsp_item_type          rsp_data_ff;

   logic [CNT_W:0]        trial;
   logic                  take;
   logic [DIFF_W-1:0]     diff;
   logic [SPEED_W-1:0]    base16;
   logic [K_W-FRAC_W-1:0] kk;
   logic [SPEED_W:0]      boost_sum;
   logic [SPEED_W-1:0]    boost;
   logic                  load;
   rsp_item_type          result;

   // restoring divide step, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign take  = (trial >= {1'b0, div_ff});

   // offset of the centroid from the centre column
   assign diff = DIFF_W'(cfg.image_width[IMG_W-1:1]) - {1'b0, quo_ff};

   // proportional boost, saturated
   assign base16    = {cfg.base_speed, {FRAC_W{1'b0}}};
   assign kk        = k_ff[K_W-1:FRAC_W];
   assign boost_sum = {1'b0, base16} + {1'b0, kk[SPEED_W-1:0]};
   assign boost     = (boost_sum[SPEED_W] || (|kk[K_W-FRAC_W-1:SPEED_W])) ?
                      SPEED_MAX : boost_sum[SPEED_W-1:0];

   // result selection
   always_comb begin
      result.left_speed   = base16;
      result.right_speed  = base16;
      result.steer_action = ACT_FORWARD;
      result.finish_line  = 1'b0;
      if (finish_ff) begin
         result.steer_action = ACT_FINISH;
         result.finish_line  = 1'b1;
      end else if (spin_ff) begin
         result.left_speed   = quo_ff[SPEED_W-1:0];
         result.right_speed  = '0;
         result.steer_action = ACT_SPIN;
      end else if (pos_ff) begin
         result.right_speed  = boost;
         result.steer_action = ACT_LEFT;
      end else if (neg_ff) begin
         result.left_speed   = boost;
         result.steer_action = ACT_RIGHT;
      end
   end

   assign load = (state_ff == BK_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign pop  = (state_ff == BK_IDLE) && !qstat.empty;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               step_in  = STEP_W'(SUM_W);
               state_in = pop_data.black ? BK_DONE : BK_DIV;
            end
         end
         BK_DIV: begin
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = BK_DIFF;
            end
         end
         BK_DIFF: begin
            state_in = spin_ff ? BK_DONE : BK_MUL;
         end
         BK_MUL: begin
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               finish_ff <= pop_data.black;
               spin_ff   <= (pop_data.count == '0);
               pos_ff    <= 1'b0;
               neg_ff    <= 1'b0;
               rem_ff    <= '0;
               gp_ff     <= cfg.base_speed * cfg.steer_gain;
               if (pop_data.count == '0) begin
                  quo_ff <= SUM_W'({cfg.base_speed, {SPIN_SHIFT{1'b0}}});
                  div_ff <= SPIN_DIVISOR;
               end else begin
                  quo_ff <= pop_data.sum;
                  div_ff <= pop_data.count;
               end
            end
         end
         BK_DIV: begin
            if (take) begin
               rem_ff <= CNT_W'(trial - {1'b0, div_ff});
            end else begin
               rem_ff <= trial[CNT_W-1:0];
            end
            quo_ff <= {quo_ff[SUM_W-2:0], take};
         end
         BK_DIFF: begin
            pos_ff <= !diff[DIFF_W-1] && (diff != '0);
            neg_ff <= diff[DIFF_W-1];
            mag_ff <= diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
         end
         BK_MUL: begin
            k_ff <= gp_ff * mag_ff;
         end
         default: begin
         end
      endcase
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/line_centroid_steering_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_centroid_steering_unit
// Proportional line-follower steering from the centroid of white pixels
// in one camera scan row.
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+-------------------------------
//  req     | req_valid, req_stall, req_data | one rgb pixel, last-of-row mark
//  rsp     | rsp_valid, rsp_stall, rsp_data | wheel speeds, action, finish
//  csr     | csr_we, csr_index, csr_wdata   | register write, no read-back
//
//  pixels are taken one per cycle; the front stalls only while the row
//  queue (two row summaries) is full.
//  each row end holds the back through a pop, 19 divide steps (one
//  quotient bit each), an offset step, a multiply and a load, plus the
//  wait for the result register; a spin row skips the multiply, and a
//  finish row goes from the pop straight to the load.
//  short rows are paced by the back rather than by the pixel input.
//  after a finish row all pixels are taken and dropped until reset.
//  reset is synchronous, clears the row, queue and sequencer and reloads the config reset values.
// ----------------------------------------------------------------------------
module line_centroid_steering_unit import lcs_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type qstat;
   logic             push, pop;
   row_sum_type      push_data, pop_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_SPEED:      cfg_in.base_speed      = csr_wdata[BASE_W-1:0];
            CSR_STEER_GAIN:      cfg_in.steer_gain      = csr_wdata[GAIN_W-1:0];
            CSR_WHITE_THRESHOLD: cfg_in.white_threshold = csr_wdata[CH_W-1:0];
            CSR_BLACK_THRESHOLD: cfg_in.black_threshold = csr_wdata[CH_W-1:0];
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata[IMG_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed      <= BASE_SPEED_RST;
         cfg_ff.steer_gain      <= STEER_GAIN_RST;
         cfg_ff.white_threshold <= WHITE_THRESHOLD_RST;
         cfg_ff.black_threshold <= BLACK_THRESHOLD_RST;
         cfg_ff.image_width     <= IMAGE_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pixel front
   lcs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // row summary queue
   lcs_row_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   // row-end engine
   lcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
